// ----- rtl/core/pgv_pkg.sv -----
package pgv_pkg;

  // Width of the force divisor register and its value after reset.
  localparam int unsigned DIV_W = 8;
  localparam logic [DIV_W-1:0] DIV_RESET = 8'd10;

  // Body masses are plain unsigned integers.
  localparam int unsigned MASS_W = 16;

endpackage

// ----- rtl/core/pgv_sqrt.sv -----
module pgv_sqrt #(
  parameter int IN_W = 8,
  parameter int SB_W = 1
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    valid_i,
  input  logic [IN_W-1:0]         rad_i,
  input  logic [SB_W-1:0]         sb_i,
  output logic                    valid_o,
  output logic [(IN_W+1)/2-1:0]   root_o,
  output logic [SB_W-1:0]         sb_o
);

  localparam int OW = (IN_W + 1) / 2;
  localparam int TW = 2 * OW + 1;

  logic [OW-1:0]   valid_q;
  logic [IN_W-1:0] rem_q  [OW-1];
  logic [OW-1:0]   root_q [OW];
  logic [SB_W-1:0] sb_q   [OW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[OW-2:0], valid_i};
    end
  end

  // One result bit per stage, most significant first.
  for (genvar k = 0; k < OW; k++) begin : g_stage
    localparam int I = OW - 1 - k;
    logic [IN_W-1:0] rem_in;
    logic [OW-1:0]   root_in;
    logic [SB_W-1:0] sb_in;
    logic [TW-1:0]   trial;
    logic            take;

    if (k == 0) begin : g_first
      assign rem_in  = rad_i;
      assign root_in = '0;
      assign sb_in   = sb_i;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign sb_in   = sb_q[k-1];
    end

    assign trial = (TW'(root_in) << (I + 1)) | (TW'(1) << (2 * I));
    assign take  = TW'(rem_in) >= trial;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        root_q[k] <= take ? (root_in | (OW'(1) << I)) : root_in;
        sb_q[k]   <= sb_in;
      end
    end

    if (k < OW - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[k] <= take ? (rem_in - trial[IN_W-1:0]) : rem_in;
        end
      end
    end
  end

  assign valid_o = valid_q[OW-1];
  assign root_o  = root_q[OW-1];
  assign sb_o    = sb_q[OW-1];

endmodule

// ----- rtl/core/pgv_div.sv -----
module pgv_div #(
  parameter int NUM_W = 8,
  parameter int DEN_W = 8,
  parameter int QB    = 4,
  parameter int SB_W  = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  input  logic [SB_W-1:0]  sb_i,
  output logic             valid_o,
  output logic [QB:0]      quo_o,
  output logic [SB_W-1:0]  sb_o
);

  // The quotient is clamped to 2^QB; the first stage detects that case.
  localparam int RW = DEN_W + QB;
  localparam int CW = (NUM_W > RW) ? NUM_W : RW;

  logic [CW-1:0]    num_x;
  logic [CW-1:0]    lim_x;
  logic [QB:0]      valid_q;
  logic [QB:0]      ov_q;
  logic [RW-1:0]    rem_q [QB];
  logic [DEN_W-1:0] den_q [QB];
  logic [QB-1:0]    quo_q [QB+1];
  logic [SB_W-1:0]  sb_q  [QB+1];

  assign num_x = CW'(num_i);
  assign lim_x = CW'(den_i) << QB;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[QB-1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= num_x[RW-1:0];
      den_q[0] <= den_i;
      quo_q[0] <= '0;
      ov_q[0]  <= num_x >= lim_x;
      sb_q[0]  <= sb_i;
    end
  end

  // Restoring division, one quotient bit per stage.
  for (genvar k = 1; k <= QB; k++) begin : g_stage
    localparam int I = QB - k;
    logic [RW-1:0] trial;
    logic          take;

    assign trial = RW'(den_q[k-1]) << I;
    assign take  = rem_q[k-1] >= trial;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        quo_q[k] <= take ? (quo_q[k-1] | (QB'(1) << I)) : quo_q[k-1];
        ov_q[k]  <= ov_q[k-1];
        sb_q[k]  <= sb_q[k-1];
      end
    end

    if (k < QB) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[k] <= take ? (rem_q[k-1] - trial) : rem_q[k-1];
          den_q[k] <= den_q[k-1];
        end
      end
    end
  end

  assign valid_o = valid_q[QB];
  assign quo_o   = ov_q[QB] ? {1'b1, QB'(0)} : {1'b0, quo_q[QB]};
  assign sb_o    = sb_q[QB];

endmodule

// ----- rtl/core/pairwise_gravity_velocity_update.sv -----
// Channel  Direction  Handshake                Payload
// config   in         cfg_we_i                 cfg_wdata_i (force divisor)
// in       in         in_valid_i / in_ready_o  both bodies: positions, masses, velocity
// out      out        out_valid_o / out_ready_i new_vx_o, new_vy_o, coincident_o, saturated_o
//
// One item enters per clock cycle while the output is not stalled; the square root
// and the dividers each produce one result bit per stage.
// The whole pipeline advances together: it moves whenever the output register is
// empty or being taken, so a stalled output holds every stage in place.
// Reset clears the stage valid bits and loads the force divisor with 10.
// Payload registers are not reset.
module pairwise_gravity_velocity_update
  import pgv_pkg::*;
#(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [DIV_W-1:0]            cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic signed [WORD_BITS-1:0] fixed_x_i,
  input  logic signed [WORD_BITS-1:0] fixed_y_i,
  input  logic [MASS_W-1:0]           fixed_mass_i,
  input  logic signed [WORD_BITS-1:0] moving_x_i,
  input  logic signed [WORD_BITS-1:0] moving_y_i,
  input  logic signed [WORD_BITS-1:0] moving_vx_i,
  input  logic signed [WORD_BITS-1:0] moving_vy_i,
  input  logic [MASS_W-1:0]           moving_mass_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic signed [WORD_BITS-1:0] new_vx_o,
  output logic signed [WORD_BITS-1:0] new_vy_o,
  output logic                        coincident_o,
  output logic                        saturated_o
);

  localparam int W    = WORD_BITS;
  localparam int F    = FRAC_BITS;
  localparam int SW   = 2 * W + 1;            // sum of squared offsets
  localparam int RTW  = W + 1;                // distance
  localparam int MW   = 2 * MASS_W;           // mass product
  localparam int UW   = F + 1;                // unit vector component
  localparam int DENW = 2 * RTW + DIV_W;      // d^2 * divisor
  localparam int FQB  = W + F + 1;            // force quotient bits below the cap
  localparam int FW   = FQB + 1;              // force, capped at 2^(W+F+1)
  localparam int PW   = FW + UW;              // force times unit component
  localparam int KW   = W + 2;                // kick, capped at 2^(W+1)
  localparam int S1W  = 2 * W + 3 + MW + 2 * W;
  localparam int SXW  = RTW + 2 + MW + W;
  localparam int SYW  = 1 + W;
  localparam int SFW  = 2 * UW + 3 + 2 * W;
  localparam logic [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};

  logic adv;
  logic out_valid_q;

  // The pipeline moves as one; the output register frees a slot when it is taken.
  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv;

  // Force divisor register. A value of zero behaves as one.
  logic [DIV_W-1:0] force_divisor_q;
  logic [DIV_W-1:0] div_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      force_divisor_q <= DIV_RESET;
    end else if (cfg_we_i) begin
      force_divisor_q <= cfg_wdata_i;
    end
  end

  assign div_eff = (force_divisor_q == '0) ? DIV_W'(1) : force_divisor_q;

  // Stage A: offsets from the moving body to the attracting body, as sign and
  // magnitude. The offsets are one bit wider than a word and never overflow.
  logic [W:0]   dx_c, dy_c, ndx_c, ndy_c;
  logic         a_valid_q;
  logic [W-1:0] a_ax_q, a_ay_q, a_vx_q, a_vy_q;
  logic         a_sx_q, a_sy_q, a_coin_q;
  logic [MASS_W-1:0] a_m1_q, a_m2_q;

  assign dx_c  = {fixed_x_i[W-1], fixed_x_i} - {moving_x_i[W-1], moving_x_i};
  assign dy_c  = {fixed_y_i[W-1], fixed_y_i} - {moving_y_i[W-1], moving_y_i};
  assign ndx_c = (W+1)'(0) - dx_c;
  assign ndy_c = (W+1)'(0) - dy_c;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_ax_q   <= dx_c[W] ? ndx_c[W-1:0] : dx_c[W-1:0];
      a_ay_q   <= dy_c[W] ? ndy_c[W-1:0] : dy_c[W-1:0];
      a_sx_q   <= dx_c[W];
      a_sy_q   <= dy_c[W];
      a_coin_q <= (dx_c == '0) && (dy_c == '0);
      a_m1_q   <= fixed_mass_i;
      a_m2_q   <= moving_mass_i;
      a_vx_q   <= moving_vx_i;
      a_vy_q   <= moving_vy_i;
    end
  end

  // Stage B: squared offsets and the mass product.
  logic           b_valid_q;
  logic [2*W-1:0] sqx_d, sqy_d, b_sqx_q, b_sqy_q;
  logic [MW-1:0]  mm_d, b_mm_q;
  logic [W-1:0]   b_ax_q, b_ay_q, b_vx_q, b_vy_q;
  logic           b_sx_q, b_sy_q, b_coin_q;

  assign sqx_d = (2*W)'(a_ax_q) * (2*W)'(a_ax_q);
  assign sqy_d = (2*W)'(a_ay_q) * (2*W)'(a_ay_q);
  assign mm_d  = MW'(a_m1_q) * MW'(a_m2_q);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      b_sqx_q  <= sqx_d;
      b_sqy_q  <= sqy_d;
      b_mm_q   <= mm_d;
      b_ax_q   <= a_ax_q;
      b_ay_q   <= a_ay_q;
      b_sx_q   <= a_sx_q;
      b_sy_q   <= a_sy_q;
      b_coin_q <= a_coin_q;
      b_vx_q   <= a_vx_q;
      b_vy_q   <= a_vy_q;
    end
  end

  // Stage C: squared distance.
  logic          c_valid_q;
  logic [SW-1:0] c_sum_q;
  logic [MW-1:0] c_mm_q;
  logic [W-1:0]  c_ax_q, c_ay_q, c_vx_q, c_vy_q;
  logic          c_sx_q, c_sy_q, c_coin_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      c_sum_q  <= SW'(b_sqx_q) + SW'(b_sqy_q);
      c_mm_q   <= b_mm_q;
      c_ax_q   <= b_ax_q;
      c_ay_q   <= b_ay_q;
      c_sx_q   <= b_sx_q;
      c_sy_q   <= b_sy_q;
      c_coin_q <= b_coin_q;
      c_vx_q   <= b_vx_q;
      c_vy_q   <= b_vy_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
    end else if (adv) begin
      a_valid_q <= in_valid_i;
      b_valid_q <= a_valid_q;
      c_valid_q <= b_valid_q;
    end
  end

  // Distance: floor of the square root, one bit per stage.
  logic           s_valid;
  logic [RTW-1:0] s_root;
  logic [S1W-1:0] s_sb;
  logic [W-1:0]   s_ax, s_ay, s_vx, s_vy;
  logic           s_sx, s_sy, s_coin;
  logic [MW-1:0]  s_mm;

  pgv_sqrt #(
    .IN_W (SW),
    .SB_W (S1W)
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (c_valid_q),
    .rad_i   (c_sum_q),
    .sb_i    ({c_ax_q, c_ay_q, c_sx_q, c_sy_q, c_coin_q, c_mm_q, c_vx_q, c_vy_q}),
    .valid_o (s_valid),
    .root_o  (s_root),
    .sb_o    (s_sb)
  );

  assign {s_ax, s_ay, s_sx, s_sy, s_coin, s_mm, s_vx, s_vy} = s_sb;

  // Unit vector components |d|/dist, in FRAC_BITS fraction bits. The magnitude
  // never exceeds the distance, so each component is at most one.
  logic           ux_valid, uy_valid;
  logic [UW-1:0]  ux, uy;
  logic [SXW-1:0] ux_sb;
  logic [SYW-1:0] uy_sb;
  logic [RTW-1:0] u_root;
  logic           u_sx, u_sy, u_coin;
  logic [MW-1:0]  u_mm;
  logic [W-1:0]   u_vx, u_vy;

  pgv_div #(
    .NUM_W (W + F),
    .DEN_W (RTW),
    .QB    (F),
    .SB_W  (SXW)
  ) u_div_ux (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (s_valid),
    .num_i   ({s_ax, F'(0)}),
    .den_i   (s_root),
    .sb_i    ({s_root, s_sx, s_coin, s_mm, s_vx}),
    .valid_o (ux_valid),
    .quo_o   (ux),
    .sb_o    (ux_sb)
  );

  pgv_div #(
    .NUM_W (W + F),
    .DEN_W (RTW),
    .QB    (F),
    .SB_W  (SYW)
  ) u_div_uy (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (s_valid),
    .num_i   ({s_ay, F'(0)}),
    .den_i   (s_root),
    .sb_i    ({s_sy, s_vy}),
    .valid_o (uy_valid),
    .quo_o   (uy),
    .sb_o    (uy_sb)
  );

  assign {u_root, u_sx, u_coin, u_mm, u_vx} = ux_sb;
  assign {u_sy, u_vy} = uy_sb;

  // Stage E: squared distance as the divider sees it (floor of the distance, squared).
  logic             e_valid_q;
  logic [2*RTW-1:0] dd_d, e_dd_q;
  logic [UW-1:0]    e_ux_q, e_uy_q;
  logic             e_sx_q, e_sy_q, e_coin_q;
  logic [MW-1:0]    e_mm_q;
  logic [W-1:0]     e_vx_q, e_vy_q;

  assign dd_d = (2*RTW)'(u_root) * (2*RTW)'(u_root);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      e_dd_q   <= dd_d;
      e_ux_q   <= ux;
      e_uy_q   <= uy;
      e_sx_q   <= u_sx;
      e_sy_q   <= u_sy;
      e_coin_q <= u_coin;
      e_mm_q   <= u_mm;
      e_vx_q   <= u_vx;
      e_vy_q   <= u_vy;
    end
  end

  // Stage F: force denominator, distance squared times the divisor.
  logic            f_valid_q;
  logic [DENW-1:0] den_d, f_den_q;
  logic [UW-1:0]   f_ux_q, f_uy_q;
  logic            f_sx_q, f_sy_q, f_coin_q;
  logic [MW-1:0]   f_mm_q;
  logic [W-1:0]    f_vx_q, f_vy_q;

  assign den_d = DENW'(e_dd_q) * DENW'(div_eff);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      f_den_q  <= den_d;
      f_ux_q   <= e_ux_q;
      f_uy_q   <= e_uy_q;
      f_sx_q   <= e_sx_q;
      f_sy_q   <= e_sy_q;
      f_coin_q <= e_coin_q;
      f_mm_q   <= e_mm_q;
      f_vx_q   <= e_vx_q;
      f_vy_q   <= e_vy_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_valid_q <= 1'b0;
      f_valid_q <= 1'b0;
    end else if (adv) begin
      e_valid_q <= ux_valid;
      f_valid_q <= e_valid_q;
    end
  end

  // Force m1*m2 / (d^2 * divisor) in FRAC_BITS fraction bits. Anything at or
  // above the cap drives the velocity into saturation, so the divider clamps it.
  logic           fq_valid;
  logic [FW-1:0]  fq;
  logic [SFW-1:0] fq_sb;
  logic [UW-1:0]  q_ux, q_uy;
  logic           q_sx, q_sy, q_coin;
  logic [W-1:0]   q_vx, q_vy;

  pgv_div #(
    .NUM_W (MW + 3 * F),
    .DEN_W (DENW),
    .QB    (FQB),
    .SB_W  (SFW)
  ) u_div_force (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (f_valid_q),
    .num_i   ({f_mm_q, (3*F)'(0)}),
    .den_i   (f_den_q),
    .sb_i    ({f_ux_q, f_uy_q, f_sx_q, f_sy_q, f_coin_q, f_vx_q, f_vy_q}),
    .valid_o (fq_valid),
    .quo_o   (fq),
    .sb_o    (fq_sb)
  );

  assign {q_ux, q_uy, q_sx, q_sy, q_coin, q_vx, q_vy} = fq_sb;

  // Stage G: force along each axis, still with the extra fraction bits.
  logic          g_valid_q;
  logic [PW-1:0] px_d, py_d, g_px_q, g_py_q;
  logic          g_sx_q, g_sy_q, g_coin_q;
  logic [W-1:0]  g_vx_q, g_vy_q;

  assign px_d = PW'(fq) * PW'(q_ux);
  assign py_d = PW'(fq) * PW'(q_uy);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      g_px_q   <= px_d;
      g_py_q   <= py_d;
      g_sx_q   <= q_sx;
      g_sy_q   <= q_sy;
      g_coin_q <= q_coin;
      g_vx_q   <= q_vx;
      g_vy_q   <= q_vy;
    end
  end

  // Stage H: drop the extra fraction bits and cap each kick at 2^(W+1), which
  // already lies beyond any velocity that can avoid saturation.
  logic          h_valid_q;
  logic [KW-1:0] kx_d, ky_d, h_kx_q, h_ky_q;
  logic          h_sx_q, h_sy_q, h_coin_q;
  logic [W-1:0]  h_vx_q, h_vy_q;

  assign kx_d = (g_px_q[PW-1:F+W+1] != '0) ? {1'b1, (W+1)'(0)} : {1'b0, g_px_q[F+W:F]};
  assign ky_d = (g_py_q[PW-1:F+W+1] != '0) ? {1'b1, (W+1)'(0)} : {1'b0, g_py_q[F+W:F]};

  always_ff @(posedge clk_i) begin
    if (adv) begin
      h_kx_q   <= kx_d;
      h_ky_q   <= ky_d;
      h_sx_q   <= g_sx_q;
      h_sy_q   <= g_sy_q;
      h_coin_q <= g_coin_q;
      h_vx_q   <= g_vx_q;
      h_vy_q   <= g_vy_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      g_valid_q <= 1'b0;
      h_valid_q <= 1'b0;
    end else if (adv) begin
      g_valid_q <= fq_valid;
      h_valid_q <= g_valid_q;
    end
  end

  // Output stage: apply the kick with its sign and clamp to the word range.
  // Coincident bodies keep their velocity and never report saturation.
  logic [W+2:0] sum_x, sum_y, kxe, kye;
  logic         ovf_x, ovf_y;
  logic [W-1:0] clx, cly;
  logic [W-1:0] out_vx_q, out_vy_q;
  logic         out_coin_q, out_sat_q;

  assign kxe   = h_sx_q ? ((W+3)'(0) - (W+3)'(h_kx_q)) : (W+3)'(h_kx_q);
  assign kye   = h_sy_q ? ((W+3)'(0) - (W+3)'(h_ky_q)) : (W+3)'(h_ky_q);
  assign sum_x = {{3{h_vx_q[W-1]}}, h_vx_q} + kxe;
  assign sum_y = {{3{h_vy_q[W-1]}}, h_vy_q} + kye;
  assign ovf_x = (sum_x[W+2:W-1] != '0) && (sum_x[W+2:W-1] != '1);
  assign ovf_y = (sum_y[W+2:W-1] != '0) && (sum_y[W+2:W-1] != '1);
  assign clx   = ovf_x ? (sum_x[W+2] ? VMIN : VMAX) : sum_x[W-1:0];
  assign cly   = ovf_y ? (sum_y[W+2] ? VMIN : VMAX) : sum_y[W-1:0];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_vx_q   <= h_coin_q ? h_vx_q : clx;
      out_vy_q   <= h_coin_q ? h_vy_q : cly;
      out_coin_q <= h_coin_q;
      out_sat_q  <= !h_coin_q && (ovf_x || ovf_y);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= h_valid_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign new_vx_o     = out_vx_q;
  assign new_vy_o     = out_vy_q;
  assign coincident_o = out_coin_q;
  assign saturated_o  = out_sat_q;

  // The two unit vector dividers run in lockstep.
  assert property (@(posedge clk_i) disable iff (!rst_ni) ux_valid == uy_valid)
    else $error("unit vector dividers out of step");

  // Coincident bodies never report saturation.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && coincident_o |-> !saturated_o)
    else $error("saturation reported for coincident bodies");

  // A saturated item has at least one component at a rail.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && saturated_o |->
      (out_vx_q == VMAX) || (out_vx_q == VMIN) || (out_vy_q == VMAX) || (out_vy_q == VMIN))
    else $error("saturation flag without a clamped component");

  // A stall freezes the pipeline.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(h_kx_q) && $stable(h_valid_q))
    else $error("pipeline moved during a stall");

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps

// Self-checking bench for the pairwise gravity velocity update.
// Every item accepted on the input side is run through a local predictor, and its
// expected velocity and flags are queued. Every item taken on the output side is
// compared, field by field, against the oldest entry in that queue.
module tb_top;
  import pgv_pkg::*;

  localparam int WB = 32;
  localparam int FB = 16;
  // This settle time is used before any divisor write and at the end of the run.
  localparam int SETTLE = 3 * WB + 2 * FB + 40;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic signed [WB-1:0] vx;
    logic signed [WB-1:0] vy;
    logic                 coin;
    logic                 sat;
  } kick_result_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [DIV_W-1:0]     cfg_wdata_i;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic signed [WB-1:0] fixed_x_i;
  logic signed [WB-1:0] fixed_y_i;
  logic [MASS_W-1:0]    fixed_mass_i;
  logic signed [WB-1:0] moving_x_i;
  logic signed [WB-1:0] moving_y_i;
  logic signed [WB-1:0] moving_vx_i;
  logic signed [WB-1:0] moving_vy_i;
  logic [MASS_W-1:0]    moving_mass_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic signed [WB-1:0] new_vx_o;
  logic signed [WB-1:0] new_vy_o;
  logic                 coincident_o;
  logic                 saturated_o;

  // The predictor keeps its own copy of the divisor register.
  logic [DIV_W-1:0]     divisor_shadow;
  kick_result_t         pending_kicks[$];
  int                   fail_count;
  int                   cycle_count;
  // When set, neither side inserts idle cycles.
  logic                 no_idle;

  pairwise_gravity_velocity_update #(
    .WORD_BITS(WB),
    .FRAC_BITS(FB)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .fixed_x_i     (fixed_x_i),
    .fixed_y_i     (fixed_y_i),
    .fixed_mass_i  (fixed_mass_i),
    .moving_x_i    (moving_x_i),
    .moving_y_i    (moving_y_i),
    .moving_vx_i   (moving_vx_i),
    .moving_vy_i   (moving_vy_i),
    .moving_mass_i (moving_mass_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .new_vx_o      (new_vx_o),
    .new_vy_o      (new_vy_o),
    .coincident_o  (coincident_o),
    .saturated_o   (saturated_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Floor of the square root, built up one result bit at a time.
  function automatic logic [127:0] floor_sqrt(input logic [127:0] n);
    logic [127:0] root;
    logic [127:0] trial;
    root = '0;
    for (int i = 40; i >= 0; i--) begin
      trial = root | (128'd1 << i);
      if (trial * trial <= n) root = trial;
    end
    return root;
  endfunction

  // Works out the velocity after one gravity kick. All divisions truncate, the
  // force and the kick are capped well beyond the point of saturation, and the
  // kick takes the sign of the offset on each axis.
  function automatic kick_result_t predict_kick(
    input logic signed [WB-1:0] fx, input logic signed [WB-1:0] fy,
    input logic [MASS_W-1:0] m1,
    input logic signed [WB-1:0] mx, input logic signed [WB-1:0] my,
    input logic signed [WB-1:0] vx, input logic signed [WB-1:0] vy,
    input logic [MASS_W-1:0] m2, input logic [DIV_W-1:0] divisor);
    kick_result_t r;
    longint       dx;
    longint       dy;
    longint       sum_x;
    longint       sum_y;
    longint       hi_lim;
    longint       lo_lim;
    logic [127:0] ax, ay, dist_raw, num, den, force_raw, ux, uy, kx, ky, div_eff;
    dx = longint'(fx) - longint'(mx);
    dy = longint'(fy) - longint'(my);
    hi_lim = (64'sd1 <<< (WB - 1)) - 1;
    lo_lim = -hi_lim - 1;
    r.vx = vx;
    r.vy = vy;
    r.coin = (dx == 0) && (dy == 0);
    r.sat = 1'b0;
    if (!r.coin) begin
      ax = 128'(dx < 0 ? -dx : dx);
      ay = 128'(dy < 0 ? -dy : dy);
      div_eff = (divisor == 0) ? 128'd1 : 128'(divisor);
      dist_raw = floor_sqrt(ax * ax + ay * ay);
      num = (128'(m1) * 128'(m2)) << (3 * FB);
      den = dist_raw * dist_raw * div_eff;
      force_raw = num / den;
      if (force_raw > (128'd1 << (WB + FB + 1))) force_raw = 128'd1 << (WB + FB + 1);
      ux = (ax << FB) / dist_raw;
      uy = (ay << FB) / dist_raw;
      kx = (force_raw * ux) >> FB;
      ky = (force_raw * uy) >> FB;
      if (kx > (128'd1 << (WB + 1))) kx = 128'd1 << (WB + 1);
      if (ky > (128'd1 << (WB + 1))) ky = 128'd1 << (WB + 1);
      sum_x = longint'(vx) + (dx < 0 ? -longint'(kx) : longint'(kx));
      sum_y = longint'(vy) + (dy < 0 ? -longint'(ky) : longint'(ky));
      if (sum_x > hi_lim) begin
        sum_x = hi_lim;
        r.sat = 1'b1;
      end else if (sum_x < lo_lim) begin
        sum_x = lo_lim;
        r.sat = 1'b1;
      end
      if (sum_y > hi_lim) begin
        sum_y = hi_lim;
        r.sat = 1'b1;
      end else if (sum_y < lo_lim) begin
        sum_y = lo_lim;
        r.sat = 1'b1;
      end
      r.vx = sum_x[WB-1:0];
      r.vy = sum_y[WB-1:0];
    end
    return r;
  endfunction

  // Input side: every accepted item gets its prediction queued at the edge
  // where it is taken, using the divisor that the block holds at that time.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) begin
      pending_kicks.push_back(predict_kick(fixed_x_i, fixed_y_i, fixed_mass_i,
                                           moving_x_i, moving_y_i, moving_vx_i,
                                           moving_vy_i, moving_mass_i, divisor_shadow));
    end
  end

  // Output side: stall at random unless the quiet stretch is on.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= no_idle ? 1'b1 : ($urandom_range(99) >= 14);
    end
  end

  // Compare each taken item against the oldest expectation.
  always @(posedge clk_i) begin
    kick_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_kicks.size() == 0) begin
        $display("%0t: item out with nothing expected: vx %h vy %h coin %b sat %b",
                 $time, new_vx_o, new_vy_o, coincident_o, saturated_o);
        fail_count++;
      end else begin
        want = pending_kicks.pop_front();
        if (new_vx_o !== want.vx) begin
          $display("%0t: new_vx expected %h actual %h", $time, want.vx, new_vx_o);
          fail_count++;
        end
        if (new_vy_o !== want.vy) begin
          $display("%0t: new_vy expected %h actual %h", $time, want.vy, new_vy_o);
          fail_count++;
        end
        if (coincident_o !== want.coin) begin
          $display("%0t: coincident expected %b actual %b", $time, want.coin,
                   coincident_o);
          fail_count++;
        end
        if (saturated_o !== want.sat) begin
          $display("%0t: saturated expected %b actual %b", $time, want.sat,
                   saturated_o);
          fail_count++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Presents one item and holds it until the block takes it. Valid stays high
  // afterward so that back-to-back items need no extra cycle.
  task automatic send_pair(
    input logic signed [WB-1:0] fx, input logic signed [WB-1:0] fy,
    input logic [MASS_W-1:0] m1,
    input logic signed [WB-1:0] mx, input logic signed [WB-1:0] my,
    input logic signed [WB-1:0] vx, input logic signed [WB-1:0] vy,
    input logic [MASS_W-1:0] m2);
    while (!no_idle && $urandom_range(99) < 14) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    fixed_x_i     <= fx;
    fixed_y_i     <= fy;
    fixed_mass_i  <= m1;
    moving_x_i    <= mx;
    moving_y_i    <= my;
    moving_vx_i   <= vx;
    moving_vy_i   <= vy;
    moving_mass_i <= m2;
    in_valid_i    <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Lowers valid, lets every expected item drain and then lets the pipeline
  // empty out completely.
  task automatic drain_pipeline();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_kicks.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_divisor(input logic [DIV_W-1:0] value);
    drain_pipeline();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    divisor_shadow = value;
  endtask

  // Random item with a mix of offset scales. Tight offsets with heavy masses
  // drive the kick into saturation, wide offsets give tiny kicks.
  task automatic send_random_pair();
    logic signed [WB-1:0] fx, fy, mx, my, vx, vy;
    logic [MASS_W-1:0]    m1, m2;
    int                   shape;
    int                   span;
    shape = $urandom_range(9);
    fx = $urandom;
    fy = $urandom;
    vx = $urandom;
    vy = $urandom;
    m1 = $urandom;
    m2 = $urandom;
    span = $urandom_range(30, 2);
    if (shape < 3) begin
      mx = $urandom;
      my = $urandom;
    end else if (shape < 9) begin
      mx = fx + WB'(signed'($urandom) >>> span);
      my = fy + WB'(signed'($urandom) >>> span);
    end else begin
      mx = fx;
      my = fy;
    end
    if ($urandom_range(9) == 0) m1 = '0;
    if ($urandom_range(9) == 0) m2 = '0;
    if ($urandom_range(3) == 0) begin
      vx = vx >>> $urandom_range(31);
      vy = vy >>> $urandom_range(31);
    end
    send_pair(fx, fy, m1, mx, my, vx, vy, m2);
  endtask

  // Extremes of every field and each special case at the reset divisor.
  task automatic test_directed_cases();
    logic signed [WB-1:0] wmax;
    logic signed [WB-1:0] wmin;
    wmax = {1'b0, {(WB - 1){1'b1}}};
    wmin = {1'b1, {(WB - 1){1'b0}}};
    // Widest possible offsets on both axes, in both directions.
    send_pair(wmax, wmax, 16'hFFFF, wmin, wmin, 0, 0, 16'hFFFF);
    send_pair(wmin, wmin, 16'hFFFF, wmax, wmax, 0, 0, 16'hFFFF);
    send_pair(wmax, wmin, 16'hFFFF, wmin, wmax, wmax, wmin, 16'hFFFF);
    // Coincident bodies, including at the corners of the range.
    send_pair(32'h0001_0000, 32'h0002_0000, 16'hFFFF, 32'h0001_0000, 32'h0002_0000,
              32'h1234_5678, -32'sd77, 16'hFFFF);
    send_pair(wmax, wmin, 16'd1, wmax, wmin, wmax, wmin, 16'd1);
    // A zero mass on either side gives no kick at all.
    send_pair(32'h0001_0000, 0, 16'd0, 0, 0, 32'h0003_0000, -32'sd5, 16'hFFFF);
    send_pair(0, 32'h0001_0000, 16'hFFFF, 0, 0, 32'h0003_0000, -32'sd5, 16'd0);
    // One raw unit apart with heavy masses saturates toward both ends.
    send_pair(1, 0, 16'hFFFF, 0, 0, 0, 0, 16'hFFFF);
    send_pair(0, -1, 16'hFFFF, 0, 0, 0, 0, 16'hFFFF);
    send_pair(-1, 1, 16'hFFFF, 0, 0, wmin, wmax, 16'hFFFF);
    // Moderate offsets, one axis only and diagonal, with masses from 1 to 500.
    send_pair(32'h0010_0000, 0, 16'd1, 0, 0, 0, 0, 16'd1);
    send_pair(0, -32'sh0010_0000, 16'd100, 0, 0, 0, 0, 16'd200);
    send_pair(32'h0003_0000, 32'h0004_0000, 16'd500, 0, 0, wmax, wmin, 16'd500);
    send_pair(-32'sh0003_0000, 32'h0004_0000, 16'd2, 32'h0000_8000, 0,
              32'h0000_0100, 32'h0000_0100, 16'd3);
    // Velocity at the word limits with a kick pushing it further out.
    send_pair(32'h0000_0100, 32'h0000_0100, 16'd9, 0, 0, wmax, wmax, 16'd9);
    send_pair(-32'sh0000_0100, -32'sh0000_0100, 16'd9, 0, 0, wmin, wmin, 16'd9);
  endtask

  // Steps the divisor through its extremes, zero (which acts as one) and a
  // few values between, with a burst of items at each setting.
  task automatic test_divisor_settings();
    logic [DIV_W-1:0] setting[5];
    setting = '{8'd1, 8'd255, 8'd0, 8'd37, 8'd128};
    foreach (setting[i]) begin
      write_divisor(setting[i]);
      repeat (12) send_random_pair();
      send_pair(32'h0000_0400, 0, 16'd300, 0, 0, 0, 0, 16'd300);
    end
  endtask

  // Long random run, with a stretch in the middle where neither side idles,
  // and a change of divisor part of the way through.
  task automatic test_random_pairs();
    write_divisor(8'd10);
    for (int i = 0; i < 1000; i++) begin
      if (i == 400) no_idle = 1'b1;
      if (i == 550) no_idle = 1'b0;
      if (i == 700) write_divisor(logic'($urandom_range(255, 1)) ? 8'($urandom_range(255, 1))
                                                               : 8'd1);
      send_random_pair();
    end
  endtask

  initial begin
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_wdata_i    = '0;
    in_valid_i     = 1'b0;
    fixed_x_i      = '0;
    fixed_y_i      = '0;
    fixed_mass_i   = '0;
    moving_x_i     = '0;
    moving_y_i     = '0;
    moving_vx_i    = '0;
    moving_vy_i    = '0;
    moving_mass_i  = '0;
    divisor_shadow = DIV_RESET;
    fail_count     = 0;
    cycle_count    = 0;
    no_idle        = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_cases();
    test_divisor_settings();
    test_random_pairs();

    drain_pipeline();
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
